/* design/kpi_pkg.sv */
// ----------------------------------------------------------------------------
// kpi_pkg
// shared types and constants of the keyframe path interpolator
// ----------------------------------------------------------------------------
package kpi_pkg;

  localparam int MAX_KEYS_DEF    = 64;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAME_WIDTH_DEF = 24;
  localparam int DUR_WIDTH       = 16;
  localparam int FRAC_BITS       = 16;
  localparam int ONE_Q           = 1 << FRAC_BITS;
  localparam int NUM_LANES       = 6;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_FETCH_END,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

/* design/keyframe_path_interpolator.sv */
// ----------------------------------------------------------------------------
// keyframe_path_interpolator
// camera keyframe store with per-frame linear interpolation in Q16.16
// ----------------------------------------------------------------------------
// usage: an item (cmd plus keyframe fields) is taken at a rising edge with
// start high and busy low. clear and load finish in that edge and give no
// result; busy stays low. tick gives exactly one result, shown for one cycle
// with done high; the receiver cannot stall it, so it must take it then.
// tick steps, accept edge to done cycle:
//   empty table: done in the next cycle (default step, no table read)
//   one key: ST_SINGLE, then done (one table read)
//   two or more keys: three reads of the key memory through its single read
//   port, then 17 quotient bits of u produced one per cycle in ST_PREP and
//   ST_DIV by a restoring divider while six shift-add lanes consume them, MSB first
// busy is high for the whole of a tick that reads the table, so a new item
// can be accepted in the done cycle; loads and clears every cycle.
// reset clears the key count, segment, frame and total; the key memory itself
// is not cleared, and entries at or above the key count are never used.
// ----------------------------------------------------------------------------
module keyframe_path_interpolator #(
  parameter int MAX_KEYS    = kpi_pkg::MAX_KEYS_DEF,
  parameter int COORD_WIDTH = kpi_pkg::COORD_WIDTH_DEF,
  parameter int FRAME_WIDTH = kpi_pkg::FRAME_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         cmd,
  input  logic [kpi_pkg::DUR_WIDTH-1:0]      duration,
  input  logic signed [COORD_WIDTH-1:0]      pos_x,
  input  logic signed [COORD_WIDTH-1:0]      pos_y,
  input  logic signed [COORD_WIDTH-1:0]      pos_z,
  input  logic signed [COORD_WIDTH-1:0]      rot_x,
  input  logic signed [COORD_WIDTH-1:0]      rot_y,
  input  logic signed [COORD_WIDTH-1:0]      rot_z,
  output logic                               done,
  output logic [FRAME_WIDTH-1:0]             frame,
  output logic signed [COORD_WIDTH-1:0]      out_pos_x,
  output logic signed [COORD_WIDTH-1:0]      out_pos_y,
  output logic signed [COORD_WIDTH-1:0]      out_pos_z,
  output logic signed [COORD_WIDTH-1:0]      out_rot_x,
  output logic signed [COORD_WIDTH-1:0]      out_rot_y,
  output logic signed [COORD_WIDTH-1:0]      out_rot_z,
  output logic                               path_valid,
  output logic [FRAME_WIDTH-1:0]             total_frames
);
  import kpi_pkg::*;

  localparam int IDX_W  = $clog2(MAX_KEYS);
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int CX_W   = CNT_W + 1;
  localparam int WORD_W = FRAME_WIDTH + NUM_LANES * COORD_WIDTH;
  localparam int ACC_W  = COORD_WIDTH + FRAC_BITS + 2;
  localparam int STEP_W = $clog2(FRAC_BITS);
  localparam logic [FRAME_WIDTH-1:0] FRAME_MAX = '1;
  localparam logic [COORD_WIDTH-1:0] NEG_ONE   = -(COORD_WIDTH'(ONE_Q));

  state_t state, state_next;

  logic [WORD_W-1:0]      mem [MAX_KEYS];
  logic [WORD_W-1:0]      rd_data;
  logic [WORD_W-1:0]      wr_word;
  logic [IDX_W-1:0]       rd_addr;

  logic [CNT_W-1:0]       key_count;
  logic [IDX_W-1:0]       segment_index;
  logic [FRAME_WIDTH-1:0] current_frame;
  logic [FRAME_WIDTH-1:0] frame_total;

  logic [FRAME_WIDTH-1:0] f0;
  logic [FRAME_WIDTH-1:0] interval;
  logic [FRAME_WIDTH-1:0] num;
  logic [FRAME_WIDTH-1:0] rem;
  logic [STEP_W-1:0]      step;
  logic                   q_top;
  logic                   q_low;
  logic                   far_out;
  logic                   zero_iv;

  logic [COORD_WIDTH-1:0]        in_lane   [NUM_LANES];
  logic [COORD_WIDTH-1:0]        rd_lane   [NUM_LANES];
  logic [COORD_WIDTH-1:0]        coord_a   [NUM_LANES];
  logic signed [COORD_WIDTH:0]   diff      [NUM_LANES];
  logic signed [ACC_W-1:0]       diff_ext  [NUM_LANES];
  logic signed [ACC_W-1:0]       acc       [NUM_LANES];
  logic [COORD_WIDTH-1:0]        out_lane  [NUM_LANES];

  logic [FRAME_WIDTH-1:0] rd_frame;
  logic [DUR_WIDTH-1:0]   dur_eff;
  logic [FRAME_WIDTH:0]   load_sum;
  logic [FRAME_WIDTH-1:0] load_total;
  logic                   load_ok;
  logic [IDX_W-1:0]       seg_eff;
  logic                   seg_last;
  logic [FRAME_WIDTH-1:0] cur_inc;
  logic                   adv;
  logic [IDX_W-1:0]       seg_new;
  logic [FRAME_WIDTH:0]   rem_sh;
  logic                   q_bit;
  logic                   q_first;

  assign in_lane[0] = pos_x;
  assign in_lane[1] = pos_y;
  assign in_lane[2] = pos_z;
  assign in_lane[3] = rot_x;
  assign in_lane[4] = rot_y;
  assign in_lane[5] = rot_z;

  assign out_pos_x = $signed(out_lane[0]);
  assign out_pos_y = $signed(out_lane[1]);
  assign out_pos_z = $signed(out_lane[2]);
  assign out_rot_x = $signed(out_lane[3]);
  assign out_rot_y = $signed(out_lane[4]);
  assign out_rot_z = $signed(out_lane[5]);

  // load path
  assign dur_eff    = (duration == '0) ? DUR_WIDTH'(1) : duration;
  assign load_sum   = (FRAME_WIDTH + 1)'(frame_total) + (FRAME_WIDTH + 1)'(dur_eff);
  assign load_total = load_sum[FRAME_WIDTH] ? FRAME_MAX : load_sum[FRAME_WIDTH-1:0];
  assign load_ok    = CX_W'(key_count) < CX_W'(MAX_KEYS);

  // segment selection
  assign rd_frame = rd_data[FRAME_WIDTH-1:0];
  assign seg_eff  = (CX_W'(segment_index) + CX_W'(2) > CX_W'(key_count)) ? '0 : segment_index;
  assign seg_last = (CX_W'(segment_index) + CX_W'(2) == CX_W'(key_count));
  assign cur_inc  = (current_frame == FRAME_MAX) ? current_frame : current_frame + 1'b1;
  assign adv      = cur_inc > rd_frame;
  assign seg_new  = !adv ? segment_index : (seg_last ? '0 : segment_index + 1'b1);

  // divider step
  assign rem_sh  = {rem, 1'b0};
  assign q_bit   = rem_sh >= {1'b0, interval};
  assign q_first = num >= interval;

  always_comb begin
    wr_word[FRAME_WIDTH-1:0] = load_total;
    for (int i = 0; i < NUM_LANES; i++) begin
      wr_word[FRAME_WIDTH + i * COORD_WIDTH +: COORD_WIDTH] = in_lane[i];
      rd_lane[i]  = rd_data[FRAME_WIDTH + i * COORD_WIDTH +: COORD_WIDTH];
      diff_ext[i] = {{(ACC_W - COORD_WIDTH - 1){diff[i][COORD_WIDTH]}}, diff[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start && cmd == CMD_TICK) begin
          if (key_count == CNT_W'(1)) begin
            state_next = ST_SINGLE;
          end else if (key_count != '0) begin
            rd_addr    = seg_eff + 1'b1;
            state_next = ST_FETCH_END;
          end
        end
      end
      ST_SINGLE: begin
        state_next = ST_IDLE;
      end
      ST_FETCH_END: begin
        rd_addr    = seg_new;
        state_next = ST_FETCH_A;
      end
      ST_FETCH_A: begin
        rd_addr    = segment_index + 1'b1;
        state_next = ST_FETCH_B;
      end
      ST_FETCH_B: begin
        state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (step == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start && cmd == CMD_LOAD && load_ok) begin
      mem[key_count[IDX_W-1:0]] <= wr_word;
    end
    rd_data <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count     <= '0;
      segment_index <= '0;
      current_frame <= '0;
      frame_total   <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            case (cmd)
              CMD_CLEAR: begin
                key_count     <= '0;
                segment_index <= '0;
                current_frame <= '0;
                frame_total   <= '0;
              end
              CMD_LOAD: begin
                if (load_ok) begin
                  frame_total <= load_total;
                  key_count   <= key_count + 1'b1;
                end
              end
              CMD_TICK: begin
                if (key_count == '0) begin
                  done <= 1'b1;
                end else begin
                  segment_index <= seg_eff;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SINGLE: begin
          done <= 1'b1;
        end
        ST_FETCH_END: begin
          current_frame <= (adv && seg_last) ? FRAME_WIDTH'(1) : cur_inc;
          segment_index <= seg_new;
        end
        ST_FETCH_A: begin
          if (current_frame < rd_frame) begin
            current_frame <= (rd_frame == FRAME_MAX) ? FRAME_MAX : rd_frame + 1'b1;
          end
        end
        ST_FINISH: begin
          done <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        path_valid   <= (key_count != '0);
        total_frames <= frame_total;
        frame        <= '0;
        for (int i = 0; i < NUM_LANES; i++) begin
          out_lane[i] <= (i == 2) ? NEG_ONE : '0;
        end
      end
      ST_SINGLE: begin
        frame <= rd_frame;
        for (int i = 0; i < NUM_LANES; i++) begin
          out_lane[i] <= rd_lane[i];
        end
      end
      ST_FETCH_A: begin
        f0 <= rd_frame;
        for (int i = 0; i < NUM_LANES; i++) begin
          coord_a[i] <= rd_lane[i];
        end
      end
      ST_FETCH_B: begin
        zero_iv  <= !(rd_frame > f0);
        interval <= (rd_frame > f0) ? rd_frame - f0 : '0;
        num      <= current_frame - f0;
        for (int i = 0; i < NUM_LANES; i++) begin
          diff[i] <= $signed({rd_lane[i][COORD_WIDTH-1], rd_lane[i]})
                   - $signed({coord_a[i][COORD_WIDTH-1], coord_a[i]});
        end
      end
      ST_PREP: begin
        far_out <= {1'b0, num} >= {interval, 1'b0};
        q_top   <= q_first;
        q_low   <= 1'b0;
        rem     <= q_first ? num - interval : num;
        step    <= STEP_W'(FRAC_BITS - 1);
        for (int i = 0; i < NUM_LANES; i++) begin
          acc[i] <= q_first ? diff_ext[i] : '0;
        end
      end
      ST_DIV: begin
        rem   <= q_bit ? FRAME_WIDTH'(rem_sh - {1'b0, interval}) : rem_sh[FRAME_WIDTH-1:0];
        q_low <= q_low | q_bit;
        step  <= step - 1'b1;
        for (int i = 0; i < NUM_LANES; i++) begin
          acc[i] <= (acc[i] <<< 1) + (q_bit ? diff_ext[i] : '0);
        end
      end
      ST_FINISH: begin
        frame <= current_frame;
        for (int i = 0; i < NUM_LANES; i++) begin
          if (zero_iv) begin
            out_lane[i] <= coord_a[i];
          end else if (far_out || (q_top && q_low)) begin
            out_lane[i] <= coord_a[i] + diff[i][COORD_WIDTH-1:0];
          end else begin
            out_lane[i] <= coord_a[i] + acc[i][FRAC_BITS +: COORD_WIDTH];
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/kpi_checker.sv */
// ----------------------------------------------------------------------------
// kpi_checker
// port-level checks of the keyframe path interpolator, bound to the top level
// ----------------------------------------------------------------------------
module kpi_checker #(
  parameter int COORD_WIDTH = kpi_pkg::COORD_WIDTH_DEF,
  parameter int FRAME_WIDTH = kpi_pkg::FRAME_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    cmd,
  input logic                          done,
  input logic [FRAME_WIDTH-1:0]        frame,
  input logic signed [COORD_WIDTH-1:0] out_pos_x,
  input logic                          path_valid
);
  import kpi_pkg::*;

  // a result is only shown while the block is free
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // clear and load never produce a result
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd != CMD_TICK) |=> !done)
    else $error("result after clear or load item");

  // a tick either finishes at once or keeps the block busy
  a_tick_work: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_TICK) |=> (done || busy))
    else $error("tick item dropped");

  // default step on an empty path
  a_empty_step: assert property (@(posedge clk) disable iff (rst)
    (done && !path_valid) |-> (frame == '0 && out_pos_x == '0))
    else $error("empty path result not the default step");

endmodule

bind keyframe_path_interpolator kpi_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .FRAME_WIDTH(FRAME_WIDTH)
) u_kpi_checker (.*);
